[rtl/bdce_pkg.sv]
// Shared types and constants of the button debounce and chord event block.
package bdce_pkg;

    localparam int DN_IDX    = 3;
    localparam int UP_IDX    = 4;
    localparam int TOOLS_IDX = 5;

    localparam int EVT_TYPE_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int TIME_W     = 32;
    localparam int TICKS_W    = 8;
    localparam int MS_W       = 16;

    localparam logic [EVT_TYPE_W-1:0] EV_SHORT       = 3'd0;
    localparam logic [EVT_TYPE_W-1:0] EV_LONG        = 3'd1;
    localparam logic [EVT_TYPE_W-1:0] EV_CHORD_SHORT = 3'd2;
    localparam logic [EVT_TYPE_W-1:0] EV_CHORD_LONG  = 3'd3;
    localparam logic [EVT_TYPE_W-1:0] EV_VIOLATION   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHORD_WINDOW_MS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS   = 2'd2;

    typedef struct packed {
        logic                  valid;
        logic [EVT_TYPE_W-1:0] etype;
    } evt_ctl_t;

endpackage

[rtl/button_debounce_chord_events.sv]
// Top level of the button debounce block with long press, chord and violation events.
//
// Usage: each transaction on the s_ channel is one poll tick carrying the raw
// pressed levels and the millisecond time of the poll. Every poll yields exactly
// one transaction on the m_ channel with the event fields, the debounced held
// mask and the ignore flag. Registers are written over the cfg_ channel, which
// is always ready; writes must happen only while the block is idle.
// A poll is first held in the input register, and its result is loaded into the
// result register from there, after which it is presented on m_. Throughput is
// one poll per cycle while the m_ receiver does not stall; the debounce and episode
// update is a single pass of logic between the input and result registers.
// When the m_ receiver stalls, the result register holds and the input register
// still takes one more poll, after which s_ready drops until the stall clears.
// Reset clears both pipeline valids, starts every button released with no
// episode in progress, and loads the register defaults of 5 ticks, 100 ms and
// 1000 ms.
module button_debounce_chord_events #(
    parameter int NUM_BUTTONS = 6
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [NUM_BUTTONS-1:0]               s_raw_pressed,
    input  logic [bdce_pkg::TIME_W-1:0]          s_now_ms,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_event_valid,
    output logic [bdce_pkg::EVT_TYPE_W-1:0]      m_event_type,
    output logic [NUM_BUTTONS-1:0]               m_event_mask,
    output logic [NUM_BUTTONS-1:0]               m_held_mask,
    output logic                                 m_ignore_active,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bdce_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bdce_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [bdce_pkg::TICKS_W-1:0]  debounce_ticks_reg;
    logic [bdce_pkg::MS_W-1:0]     chord_window_ms_reg;
    logic [bdce_pkg::MS_W-1:0]     long_press_ms_reg;

    logic                          in_valid_reg;
    logic [NUM_BUTTONS-1:0]        raw_reg;
    logic [bdce_pkg::TIME_W-1:0]   now_reg;
    logic                          out_valid_reg;
    logic                          step_en;

    logic [NUM_BUTTONS-1:0]        down;
    bdce_pkg::evt_ctl_t            evt;
    logic [NUM_BUTTONS-1:0]        evt_mask;
    logic                          ignore_next;

    assign cfg_ready = 1'b1;
    assign step_en   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || step_en;
    assign m_valid   = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ticks_reg  <= bdce_pkg::TICKS_W'(5);
            chord_window_ms_reg <= bdce_pkg::MS_W'(100);
            long_press_ms_reg   <= bdce_pkg::MS_W'(1000);
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == bdce_pkg::REG_DEBOUNCE_TICKS) begin
                debounce_ticks_reg <= cfg_data[bdce_pkg::TICKS_W-1:0];
            end else if (cfg_index == bdce_pkg::REG_CHORD_WINDOW_MS) begin
                chord_window_ms_reg <= cfg_data;
            end else if (cfg_index == bdce_pkg::REG_LONG_PRESS_MS) begin
                long_press_ms_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            raw_reg <= s_raw_pressed;
            now_reg <= s_now_ms;
        end
    end

    bdce_debounce #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) u_debounce (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .enable        (step_en),
        .raw           (raw_reg),
        .debounce_ticks(debounce_ticks_reg),
        .confirmed_next(down)
    );

    bdce_episode #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) u_episode (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .enable         (step_en),
        .down           (down),
        .now_ms         (now_reg),
        .chord_window_ms(chord_window_ms_reg),
        .long_press_ms  (long_press_ms_reg),
        .evt            (evt),
        .evt_mask       (evt_mask),
        .ignore_next    (ignore_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            m_event_valid   <= evt.valid;
            m_event_type    <= evt.etype;
            m_event_mask    <= evt_mask;
            m_held_mask     <= down;
            m_ignore_active <= ignore_next;
        end
    end

`ifndef SYNTHESIS
    a_violation_sets_ignore: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_valid && m_event_type == bdce_pkg::EV_VIOLATION |-> m_ignore_active)
        else $error("violation result without ignore flag");

    a_no_event_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_event_valid |-> m_event_type == bdce_pkg::EV_SHORT && m_event_mask == '0)
        else $error("event fields not cleared on a result without event");

    a_chord_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_valid && (m_event_type == bdce_pkg::EV_CHORD_SHORT
        || m_event_type == bdce_pkg::EV_CHORD_LONG) |-> m_event_mask ==
        ((NUM_BUTTONS'(1) << bdce_pkg::DN_IDX) | (NUM_BUTTONS'(1) << bdce_pkg::UP_IDX)))
        else $error("chord event with a mask other than DN and UP");

    a_solo_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_valid && (m_event_type == bdce_pkg::EV_SHORT
        || m_event_type == bdce_pkg::EV_LONG) |-> $onehot(m_event_mask))
        else $error("press event mask does not name exactly one button");
`endif

endmodule

[rtl/bdce_debounce.sv]
// Per-button stable-count debouncer with its confirmed level registers.
module bdce_debounce #(
    parameter int NUM_BUTTONS = 6
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              enable,
    input  logic [NUM_BUTTONS-1:0]            raw,
    input  logic [bdce_pkg::TICKS_W-1:0]      debounce_ticks,
    output logic [NUM_BUTTONS-1:0]            confirmed_next
);

    logic [NUM_BUTTONS-1:0]       last_raw_reg;
    logic [NUM_BUTTONS-1:0]       last_raw_next;
    logic [NUM_BUTTONS-1:0]       confirmed_reg;
    logic [bdce_pkg::TICKS_W-1:0] count_reg  [NUM_BUTTONS];
    logic [bdce_pkg::TICKS_W-1:0] count_next [NUM_BUTTONS];

    always_comb begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            last_raw_next[i]  = last_raw_reg[i];
            count_next[i]     = count_reg[i];
            confirmed_next[i] = confirmed_reg[i];
            if (enable) begin
                if (raw[i] == last_raw_reg[i]) begin
                    if (count_reg[i] < debounce_ticks) begin
                        count_next[i] = count_reg[i] + 1'b1;
                    end
                    if (count_next[i] >= debounce_ticks) begin
                        confirmed_next[i] = raw[i];
                    end
                end else begin
                    last_raw_next[i] = raw[i];
                    count_next[i]    = bdce_pkg::TICKS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_raw_reg  <= '0;
            confirmed_reg <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                count_reg[i] <= '0;
            end
        end else begin
            last_raw_reg  <= last_raw_next;
            confirmed_reg <= confirmed_next;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                count_reg[i] <= count_next[i];
            end
        end
    end

endmodule

[rtl/bdce_episode.sv]
// Episode state machine that turns the confirmed mask into press, chord and violation events.
module bdce_episode #(
    parameter int NUM_BUTTONS = 6
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          enable,
    input  logic [NUM_BUTTONS-1:0]        down,
    input  logic [bdce_pkg::TIME_W-1:0]   now_ms,
    input  logic [bdce_pkg::MS_W-1:0]     chord_window_ms,
    input  logic [bdce_pkg::MS_W-1:0]     long_press_ms,
    output bdce_pkg::evt_ctl_t            evt,
    output logic [NUM_BUTTONS-1:0]        evt_mask,
    output logic                          ignore_next
);

    localparam logic [2:0] EP_NONE      = 3'd0;
    localparam logic [2:0] EP_PENDING   = 3'd1;
    localparam logic [2:0] EP_SOLO      = 3'd2;
    localparam logic [2:0] EP_CHORD     = 3'd3;
    localparam logic [2:0] EP_VIOLATION = 3'd4;

    localparam logic [NUM_BUTTONS-1:0] DN_MASK    = NUM_BUTTONS'(1) << bdce_pkg::DN_IDX;
    localparam logic [NUM_BUTTONS-1:0] UP_MASK    = NUM_BUTTONS'(1) << bdce_pkg::UP_IDX;
    localparam logic [NUM_BUTTONS-1:0] TOOLS_MASK = NUM_BUTTONS'(1) << bdce_pkg::TOOLS_IDX;
    localparam logic [NUM_BUTTONS-1:0] PAIR_MASK  = DN_MASK | UP_MASK;

    logic [2:0]                    ep_reg, ep_next;
    logic [bdce_pkg::TIME_W-1:0]   t0_reg, t0_next;
    logic [NUM_BUTTONS-1:0]        act_reg, act_next;
    logic                          ld_reg, ld_next;
    logic                          ign_reg;
    logic [bdce_pkg::TIME_W-1:0]   elapsed;
    logic [bdce_pkg::TIME_W-1:0]   window_ext;
    logic [bdce_pkg::TIME_W-1:0]   long_ext;
    logic                          single;

    assign elapsed    = now_ms - t0_reg;
    assign window_ext = bdce_pkg::TIME_W'(chord_window_ms);
    assign long_ext   = bdce_pkg::TIME_W'(long_press_ms);
    assign single     = (down != '0) && ((down & (down - 1'b1)) == '0);

    always_comb begin
        ep_next     = ep_reg;
        t0_next     = t0_reg;
        act_next    = act_reg;
        ld_next     = ld_reg;
        ignore_next = ign_reg;
        evt.valid   = 1'b0;
        evt.etype   = bdce_pkg::EV_SHORT;
        evt_mask    = '0;
        if (enable) begin
            if (down == '0) begin
                if (ep_reg != EP_NONE) begin
                    if (ep_reg == EP_SOLO && !ld_reg) begin
                        evt.valid = 1'b1;
                        evt.etype = bdce_pkg::EV_SHORT;
                        evt_mask  = act_reg;
                    end else if (ep_reg == EP_CHORD && !ld_reg) begin
                        evt.valid = 1'b1;
                        evt.etype = bdce_pkg::EV_CHORD_SHORT;
                        evt_mask  = act_reg;
                    end else if (ep_reg == EP_VIOLATION) begin
                        ignore_next = 1'b0;
                    end
                    ep_next  = EP_NONE;
                    act_next = '0;
                    ld_next  = 1'b0;
                end
            end else begin
                unique case (ep_reg)
                    EP_NONE: begin
                        t0_next = now_ms;
                        ld_next = 1'b0;
                        if (single) begin
                            act_next = down;
                            ep_next  = (down == UP_MASK || down == DN_MASK) ? EP_PENDING : EP_SOLO;
                        end else begin
                            ep_next     = EP_VIOLATION;
                            ignore_next = 1'b1;
                            evt.valid   = 1'b1;
                            evt.etype   = bdce_pkg::EV_VIOLATION;
                            evt_mask    = down;
                        end
                    end
                    EP_PENDING: begin
                        if (single) begin
                            if (elapsed > window_ext) begin
                                ep_next = EP_SOLO;
                            end
                        end else if (down == PAIR_MASK && elapsed <= window_ext) begin
                            ep_next  = EP_CHORD;
                            act_next = PAIR_MASK;
                        end else begin
                            ep_next     = EP_VIOLATION;
                            ignore_next = 1'b1;
                            evt.valid   = 1'b1;
                            evt.etype   = bdce_pkg::EV_VIOLATION;
                            evt_mask    = down;
                        end
                    end
                    EP_SOLO: begin
                        if (!single || (act_reg == TOOLS_MASK && elapsed >= long_ext)) begin
                            ep_next     = EP_VIOLATION;
                            ignore_next = 1'b1;
                            evt.valid   = 1'b1;
                            evt.etype   = bdce_pkg::EV_VIOLATION;
                            evt_mask    = down;
                        end else if (act_reg != TOOLS_MASK && elapsed >= long_ext
                                     && !ld_reg) begin
                            evt.valid = 1'b1;
                            evt.etype = bdce_pkg::EV_LONG;
                            evt_mask  = act_reg;
                            ld_next   = 1'b1;
                        end
                    end
                    EP_CHORD: begin
                        if ((down & ~PAIR_MASK) != '0) begin
                            ep_next     = EP_VIOLATION;
                            ignore_next = 1'b1;
                            evt.valid   = 1'b1;
                            evt.etype   = bdce_pkg::EV_VIOLATION;
                            evt_mask    = down;
                        end else if (down == PAIR_MASK && elapsed >= long_ext && !ld_reg) begin
                            evt.valid = 1'b1;
                            evt.etype = bdce_pkg::EV_CHORD_LONG;
                            evt_mask  = act_reg;
                            ld_next   = 1'b1;
                        end
                    end
                    default: begin
                        ep_next = ep_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ep_reg  <= EP_NONE;
            t0_reg  <= '0;
            act_reg <= '0;
            ld_reg  <= 1'b0;
            ign_reg <= 1'b0;
        end else begin
            ep_reg  <= ep_next;
            t0_reg  <= t0_next;
            act_reg <= act_next;
            ld_reg  <= ld_next;
            ign_reg <= ignore_next;
        end
    end

endmodule
